// File: sv/bcfe_pkg.sv
// Package for the byte coalescer flush engine.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies; compile this file first.
package bcfe_pkg;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int MP_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Upper bound on the number of output transactions one input item may cause.
    localparam int RESULT_MAX = 64;

    localparam logic [MP_W-1:0]   MAX_PAYLOAD_RST = 7'd20;
    localparam logic [BYTE_W-1:0] DELIMITER_RST   = 8'd59;
    localparam logic [TIME_W-1:0] IDLE_LIMIT_RST  = 32'd20;
    localparam logic [TIME_W-1:0] IDLE_DEFAULT    = 32'd20;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PAYLOAD = 2'd0,
        CFG_DELIMITER   = 2'd1,
        CFG_IDLE_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

endpackage

// File: sv/bcfe_in_if.sv
// Input channel of the byte coalescer flush engine: valid/ready plus one item.
// Depends on bcfe_pkg for the field widths.
interface bcfe_in_if;
    logic                           valid;
    logic                           ready;
    logic [bcfe_pkg::OP_W-1:0]      op;
    logic [bcfe_pkg::BYTE_W-1:0]    data_byte;
    logic [bcfe_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, output op, output data_byte, output now_ms, input ready);
    modport sink   (input valid, input op, input data_byte, input now_ms, output ready);
endinterface

// File: sv/bcfe_out_if.sv
// Output channel of the byte coalescer flush engine: valid/ready plus one result.
// Depends on bcfe_pkg for the field widths.
interface bcfe_out_if;
    logic                           valid;
    logic                           ready;
    logic [bcfe_pkg::BYTE_W-1:0]    out_byte;
    logic                           chunk_last;
    logic                           dropped;

    modport source (output valid, output out_byte, output chunk_last, output dropped,
                    input ready);
    modport sink   (input valid, input out_byte, input chunk_last, input dropped,
                    output ready);
endinterface

// File: sv/byte_coalescer_flush_engine_top.sv
// Byte coalescer with automatic flush. An item that causes no chunk leaves the block
// idle. An item that flushes a chunk puts the block in its emit state: the chunk
// streams out of the single read port of the byte store at one byte per cycle, when
// the output does not stall, through the registered read data, and the next item is taken
// once the last byte has reached the output register.
// The byte store needs no clearing after reset. Uses bcfe_pkg, bcfe_in_if, bcfe_out_if.
module byte_coalescer_flush_engine_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bcfe_in_if.sink                             i_in,
    bcfe_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [bcfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bcfe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int HW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 1;

    // Configuration registers.
    logic [bcfe_pkg::MP_W-1:0]      r_max_payload;
    logic [bcfe_pkg::BYTE_W-1:0]    r_delimiter;
    logic [bcfe_pkg::TIME_W-1:0]    r_idle_limit;

    // Store bookkeeping.
    bcfe_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                  r_fill, n_fill;
    logic [HW-1:0]                  r_head, n_head;
    logic [bcfe_pkg::TIME_W-1:0]    r_lwt, n_lwt;
    logic [bcfe_pkg::BYTE_W-1:0]    r_last_byte, n_last_byte;
    logic [HW-1:0]                  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                  r_rem, n_rem;

    // Byte store and its registered read port.
    logic [bcfe_pkg::BYTE_W-1:0]    mem [BUFFER_DEPTH];
    logic [bcfe_pkg::BYTE_W-1:0]    r_rd_data;
    logic                           r_rd_last;
    logic                           r_rd_valid;

    // Output register.
    logic                           r_out_valid;
    logic [bcfe_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_out_last;
    logic                           r_out_drop;

    logic                           out_free;
    logic                           accept;
    logic                           move;
    logic                           issue;
    logic                           is_push;
    logic                           is_tick;
    logic                           is_clear;
    logic                           full;
    logic                           stored;
    logic                           echo_hit;
    logic [CW-1:0]                  fill_a;
    logic [bcfe_pkg::BYTE_W-1:0]    last_a;
    logic [bcfe_pkg::TIME_W-1:0]    lwt_a;
    logic [bcfe_pkg::TIME_W-1:0]    elapsed;
    logic [bcfe_pkg::TIME_W-1:0]    limit;
    logic [CW-1:0]                  len;
    logic [CW-1:0]                  fill_new;
    logic [HW-1:0]                  head_new;
    logic [HW-1:0]                  wr_addr;
    logic [SW-1:0]                  wr_sum;
    logic [SW-1:0]                  head_sum;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == bcfe_pkg::ST_IDLE) && !r_rd_valid && out_free;
    assign accept     = i_in.valid && i_in.ready;
    assign move       = r_rd_valid && out_free;
    assign issue      = (r_state == bcfe_pkg::ST_EMIT) && (r_rem != '0)
                        && (!r_rd_valid || move);

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.chunk_last = r_out_last;
    assign o_out.dropped    = r_out_drop;

    always_comb begin
        is_push  = 1'b0;
        is_tick  = 1'b0;
        is_clear = 1'b0;
        unique case (bcfe_pkg::t_op'(i_in.op))
            bcfe_pkg::OP_PUSH:  is_push  = 1'b1;
            bcfe_pkg::OP_TICK:  is_tick  = 1'b1;
            bcfe_pkg::OP_CLEAR: is_clear = 1'b1;
            default: ;
        endcase
    end

    // Flush decision for the item at the input, on the store as it stands after a push.
    always_comb begin
        full     = (r_fill == CW'(BUFFER_DEPTH));
        stored   = is_push && !full;
        echo_hit = is_push && full;
        fill_a   = r_fill + CW'(stored);
        last_a   = stored ? i_in.data_byte : r_last_byte;
        lwt_a    = stored ? i_in.now_ms : r_lwt;
        elapsed  = i_in.now_ms - lwt_a;
        limit    = (r_idle_limit == '0) ? bcfe_pkg::IDLE_DEFAULT : r_idle_limit;

        wr_sum  = SW'(r_head) + SW'(r_fill);
        if (wr_sum >= SW'(BUFFER_DEPTH)) begin
            wr_sum = wr_sum - SW'(BUFFER_DEPTH);
        end
        wr_addr = HW'(wr_sum);

        len = '0;
        if ((fill_a == '0) || (r_max_payload == '0)) begin
            len = '0;
        end else if (8'(fill_a) >= 8'(r_max_payload)) begin
            len = CW'(r_max_payload);
        end else if (last_a == r_delimiter) begin
            len = fill_a;
        end else if (elapsed >= limit) begin
            len = fill_a;
        end
        // The drop echo takes a result slot, so a full-size chunk is cut by one byte, which stays stored.
        if (echo_hit && (8'(len) > 8'(bcfe_pkg::RESULT_MAX - 1))) begin
            len = CW'(bcfe_pkg::RESULT_MAX - 1);
        end

        fill_new = fill_a - len;
        head_sum = SW'(r_head) + SW'(len);
        if (head_sum >= SW'(BUFFER_DEPTH)) begin
            head_sum = head_sum - SW'(BUFFER_DEPTH);
        end
        head_new = (fill_new == '0) ? '0 : HW'(head_sum);
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_head      = r_head;
        n_lwt       = r_lwt;
        n_last_byte = r_last_byte;
        n_rd_ptr    = r_rd_ptr;
        n_rem       = r_rem;
        if (accept) begin
            if (is_clear) begin
                n_fill = '0;
                n_head = '0;
            end else if (is_push || is_tick) begin
                n_fill      = fill_new;
                n_head      = head_new;
                n_lwt       = lwt_a;
                n_last_byte = last_a;
                if (len != '0) begin
                    n_state  = bcfe_pkg::ST_EMIT;
                    n_rd_ptr = r_head;
                    n_rem    = len;
                end
            end
        end else if (issue) begin
            n_rd_ptr = (r_rd_ptr == HW'(BUFFER_DEPTH - 1)) ? '0 : r_rd_ptr + HW'(1);
            n_rem    = r_rem - CW'(1);
            if (r_rem == CW'(1)) begin
                n_state = bcfe_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= bcfe_pkg::MAX_PAYLOAD_RST;
            r_delimiter   <= bcfe_pkg::DELIMITER_RST;
            r_idle_limit  <= bcfe_pkg::IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (bcfe_pkg::t_cfg_idx'(i_cfg_idx))
                bcfe_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[bcfe_pkg::MP_W-1:0];
                bcfe_pkg::CFG_DELIMITER:   r_delimiter   <= i_cfg_data[bcfe_pkg::BYTE_W-1:0];
                bcfe_pkg::CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bcfe_pkg::ST_IDLE;
            r_fill     <= '0;
            r_head     <= '0;
            r_lwt      <= '0;
            r_rem      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_head     <= n_head;
            r_lwt      <= n_lwt;
            r_rem      <= n_rem;
            r_rd_valid <= issue ? 1'b1 : (move ? 1'b0 : r_rd_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_byte <= n_last_byte;
        r_rd_ptr    <= n_rd_ptr;
    end

    // Byte store: one write port used on accepted pushes that are stored, one read port used while emitting.
    always_ff @(posedge i_clk) begin
        if (accept && stored) begin
            mem[wr_addr] <= i_in.data_byte;
        end
        if (issue) begin
            r_rd_data <= mem[r_rd_ptr];
            r_rd_last <= (r_rem == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((accept && echo_hit) || move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && echo_hit) begin
            r_out_byte <= i_in.data_byte;
            r_out_last <= 1'b0;
            r_out_drop <= 1'b1;
        end else if (move) begin
            r_out_byte <= r_rd_data;
            r_out_last <= r_rd_last;
            r_out_drop <= 1'b0;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUFFER_DEPTH))
        else $error("fill count exceeds the store depth");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_head == '0))
        else $error("read head not rewound on an empty store");

    a_emit_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcfe_pkg::ST_EMIT) |-> (r_rem != '0))
        else $error("emitting with no bytes left to read");

    a_echo_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && echo_hit) |=> (o_out.valid && o_out.dropped && !o_out.chunk_last))
        else $error("drop echo did not reach the output register");

endmodule
